@@ rtl/fqp_pkg.sv @@
// ----------------------------------------------------------------------------
// fqp_pkg
// Shared types and codes for the ordered request queue with purge by key.
// ----------------------------------------------------------------------------
package fqp_pkg;

    localparam int REQ_W    = 2;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ENQ   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEQ   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PURGE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NULL      = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [HANDLE_W-1:0] item_handle;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] removed_handle;
        logic [COUNT_W-1:0]  entry_count;
        logic                is_empty;
    } t_out_item;

endpackage

@@ rtl/fqp_slot_ram.sv @@
// ----------------------------------------------------------------------------
// fqp_slot_ram
// Slot store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fqp_slot_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fqp_seq.sv @@
// ----------------------------------------------------------------------------
// fqp_seq
// Request sequencer: decodes a request, walks the slot store through one
// shared compare and index unit, and closes the gap after a removal.
// ----------------------------------------------------------------------------
module fqp_seq #(
    parameter int QUEUE_DEPTH = 16,
    parameter int HANDLE_BITS = 16,
    localparam int SlotBits   = (HANDLE_BITS < fqp_pkg::HANDLE_W) ? HANDLE_BITS
                                                                  : fqp_pkg::HANDLE_W,
    localparam int AddrBits   = $clog2(QUEUE_DEPTH),
    localparam int CntBits    = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  fqp_pkg::t_in_item     i_item,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output fqp_pkg::t_out_item    o_res,
    output logic                  o_we,
    output logic [AddrBits-1:0]   o_waddr,
    output logic [SlotBits-1:0]   o_wdata,
    output logic [AddrBits-1:0]   o_raddr,
    input  logic [SlotBits-1:0]   i_rdata
);

    localparam int HandleW = fqp_pkg::HANDLE_W;
    localparam int CountW  = fqp_pkg::COUNT_W;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SCAN_RD  = 6'b000010,
        S_SCAN_CHK = 6'b000100,
        S_SHIFT_RD = 6'b001000,
        S_SHIFT_WR = 6'b010000,
        S_DONE     = 6'b100000
    } t_state;

    t_state                          r_state, n_state;
    logic [CntBits-1:0]              r_count, n_count;
    logic [AddrBits-1:0]             r_idx, n_idx;
    logic [SlotBits-1:0]             r_key, n_key;
    logic                            r_is_deq, n_is_deq;
    logic [fqp_pkg::STATUS_W-1:0]    r_status, n_status;
    logic [SlotBits-1:0]             r_removed, n_removed;

    logic [SlotBits-1:0] key_c;
    logic [CntBits-1:0]  idx_inc_c;
    logic [CntBits-1:0]  cnt_dec_c;
    logic                last_c;
    logic                match_c;
    logic                null_c;
    logic                full_c;
    logic                empty_c;

    // shared index / compare unit
    assign key_c     = i_item.item_handle[SlotBits-1:0];
    assign idx_inc_c = CntBits'(r_idx) + CntBits'(1);
    assign cnt_dec_c = r_count - CntBits'(1);
    assign last_c    = (idx_inc_c == r_count);
    assign match_c   = r_is_deq || (i_rdata == r_key);
    assign null_c    = (key_c == '0);
    assign full_c    = (r_count == CntBits'(QUEUE_DEPTH));
    assign empty_c   = (r_count == '0);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_key     = r_key;
        n_is_deq  = r_is_deq;
        n_status  = r_status;
        n_removed = r_removed;
        o_we      = 1'b0;
        o_waddr   = AddrBits'(r_count);
        o_wdata   = key_c;
        o_raddr   = r_idx;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_key     = key_c;
                    n_is_deq  = (i_item.req_type == fqp_pkg::REQ_DEQ);
                    n_idx     = '0;
                    n_removed = '0;
                    n_status  = fqp_pkg::ST_OK;
                    n_state   = S_DONE;
                    case (i_item.req_type)
                        fqp_pkg::REQ_ENQ: begin
                            if (null_c) begin
                                n_status = fqp_pkg::ST_NULL;
                            end else if (full_c) begin
                                n_status = fqp_pkg::ST_FULL;
                            end else begin
                                o_we    = 1'b1;
                                n_count = r_count + CntBits'(1);
                            end
                        end
                        fqp_pkg::REQ_DEQ: begin
                            if (empty_c) begin
                                n_status = fqp_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        fqp_pkg::REQ_PURGE: begin
                            if (null_c) begin
                                n_status = fqp_pkg::ST_NULL;
                            end else if (empty_c) begin
                                n_status = fqp_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        default: begin
                            n_status = fqp_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                o_raddr = r_idx;
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (match_c) begin
                    n_removed = i_rdata;
                    if (last_c) begin
                        n_count = cnt_dec_c;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SHIFT_RD;
                    end
                end else if (last_c) begin
                    n_status = fqp_pkg::ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    n_idx   = AddrBits'(idx_inc_c);
                    n_state = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                o_raddr = AddrBits'(idx_inc_c);
                n_state = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                // move the later entry one slot toward the head
                o_we    = 1'b1;
                o_waddr = r_idx;
                o_wdata = i_rdata;
                n_idx   = AddrBits'(idx_inc_c);
                if (idx_inc_c == cnt_dec_c) begin
                    n_count = cnt_dec_c;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SHIFT_RD;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx     <= n_idx;
        r_key     <= n_key;
        r_is_deq  <= n_is_deq;
        r_status  <= n_status;
        r_removed <= n_removed;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res                = '0;
        o_res.status         = r_status;
        o_res.removed_handle = HandleW'(r_removed);
        o_res.entry_count    = CountW'(r_count);
        o_res.is_empty       = empty_c;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntBits'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CHK || r_state == S_SHIFT_RD) |-> CntBits'(r_idx) < r_count)
        else $error("scan index beyond occupied slots");

    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (r_state == S_SHIFT_WR || (r_state == S_IDLE && i_valid && !full_c)))
        else $error("slot write outside enqueue or shift");

    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && i_res_ready) |=> r_state == S_IDLE)
        else $error("sequencer did not return to idle after result handoff");

    a_removal_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CHK && match_c && last_c) |=> r_count == $past(r_count) - CntBits'(1))
        else $error("removal did not drop the entry count");

endmodule

@@ rtl/fifo_queue_with_purge_core.sv @@
// ----------------------------------------------------------------------------
// fifo_queue_with_purge_core
// Ordered queue of nonzero handles with enqueue, dequeue and purge by key.
// ----------------------------------------------------------------------------
// One request at a time. Enqueue, rejected requests and the unused request
// code go straight from acceptance to the result. Dequeue and purge walk the
// slot store through its single read port: each slot is compared up to the
// match, then each later entry is moved one slot toward the head. A finished
// result sits in an output register, so the next request is taken while it
// waits. No clearing pass is needed after reset.
module fifo_queue_with_purge_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  fqp_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output fqp_pkg::t_out_item o_item
);

    localparam int SlotBits = (HANDLE_BITS < fqp_pkg::HANDLE_W) ? HANDLE_BITS
                                                                : fqp_pkg::HANDLE_W;
    localparam int AddrBits = $clog2(QUEUE_DEPTH);

    logic                res_valid;
    logic                res_ready;
    fqp_pkg::t_out_item  res;
    logic                we;
    logic [AddrBits-1:0] waddr;
    logic [SlotBits-1:0] wdata;
    logic [AddrBits-1:0] raddr;
    logic [SlotBits-1:0] rdata;

    logic                r_out_valid, n_out_valid;
    fqp_pkg::t_out_item  r_out, n_out;

    fqp_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    fqp_slot_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (SlotBits)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // output register, refilled in the cycle it is taken
    assign res_ready = !r_out_valid || i_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (res_valid && res_ready) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

@@ dv/fqp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqp_checker
// Watches both channels of the purge queue, keeps its own copy of the queue,
// predicts the reply to every accepted request and compares replies in order.
// ----------------------------------------------------------------------------
module fqp_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  fqp_pkg::t_in_item  i_req,
    input  logic               i_rsp_valid,
    input  logic               i_rsp_ready,
    input  fqp_pkg::t_out_item i_rsp,
    output int                 o_fail_cnt,
    output int                 o_pending
);

    logic [fqp_pkg::HANDLE_W-1:0] held_handles[$];
    fqp_pkg::t_out_item           expected_replies[$];
    int                           mismatches = 0;
    int                           outstanding = 0;

    assign o_fail_cnt = mismatches;
    assign o_pending  = outstanding;

    // applies one request to the shadow queue and returns the reply it earns
    function automatic fqp_pkg::t_out_item apply_request(input fqp_pkg::t_in_item req);
        fqp_pkg::t_out_item rsp;
        int                 hit;
        rsp        = '0;
        rsp.status = fqp_pkg::ST_OK;
        hit        = -1;
        case (req.req_type)
            fqp_pkg::REQ_ENQ: begin
                if (req.item_handle == '0)
                    rsp.status = fqp_pkg::ST_NULL;
                else if (held_handles.size() >= QUEUE_DEPTH)
                    rsp.status = fqp_pkg::ST_FULL;
                else
                    held_handles.push_back(req.item_handle);
            end
            fqp_pkg::REQ_DEQ: begin
                if (held_handles.size() == 0)
                    rsp.status = fqp_pkg::ST_EMPTY;
                else
                    rsp.removed_handle = held_handles.pop_front();
            end
            fqp_pkg::REQ_PURGE: begin
                if (req.item_handle == '0) begin
                    rsp.status = fqp_pkg::ST_NULL;
                end else if (held_handles.size() == 0) begin
                    rsp.status = fqp_pkg::ST_EMPTY;
                end else begin
                    // first match only, duplicates stay behind
                    foreach (held_handles[i])
                        if (hit < 0 && held_handles[i] == req.item_handle)
                            hit = i;
                    if (hit < 0) begin
                        rsp.status = fqp_pkg::ST_NOT_FOUND;
                    end else begin
                        rsp.removed_handle = held_handles[hit];
                        held_handles.delete(hit);
                    end
                end
            end
            default: ;
        endcase
        rsp.entry_count = fqp_pkg::COUNT_W'(held_handles.size());
        rsp.is_empty    = (held_handles.size() == 0);
        return rsp;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        fqp_pkg::t_out_item want;
        if (i_rst_n) begin
            // replies first: a reply never belongs to a request taken at the same edge
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected reply, expected none, actual %0h", $time, i_rsp);
                    mismatches++;
                end else begin
                    want = expected_replies.pop_front();
                    outstanding--;
                    compare_field("status", 32'(want.status), 32'(i_rsp.status));
                    compare_field("removed_handle", 32'(want.removed_handle),
                                  32'(i_rsp.removed_handle));
                    compare_field("entry_count", 32'(want.entry_count),
                                  32'(i_rsp.entry_count));
                    compare_field("is_empty", 32'(want.is_empty), 32'(i_rsp.is_empty));
                end
            end
            if (i_req_valid && i_req_ready) begin
                expected_replies.push_back(apply_request(i_req));
                outstanding++;
            end
        end
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives enqueue, dequeue and purge requests into the purge queue: a directed
// corner pass, then fill and drain bursts over a small handle pool, under
// three idle patterns. The checker beside the block judges every reply.
// ----------------------------------------------------------------------------
module testbench;

    localparam int                        QUEUE_DEPTH = 16;
    localparam int                        PHASE_ITEMS = 630;
    localparam int                        BURST_LEN   = 40;
    localparam int                        POOL_N      = 12;
    localparam int                        STALL_LIMIT = 4000;
    localparam logic [fqp_pkg::REQ_W-1:0] REQ_UNUSED  = 2'd3;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_ready = 1'b0;
    fqp_pkg::t_in_item  i_item  = '0;
    logic               o_ready;
    logic               o_valid;
    fqp_pkg::t_out_item o_item;

    int fail_cnt;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;

    logic [fqp_pkg::HANDLE_W-1:0] handle_pool[POOL_N];

    always #4 i_clk = ~i_clk;

    fifo_queue_with_purge_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .HANDLE_BITS(fqp_pkg::HANDLE_W)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_item (i_item),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_item (o_item)
    );

    fqp_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_valid),
        .i_req_ready(o_ready),
        .i_req      (i_item),
        .i_rsp_valid(o_valid),
        .i_rsp_ready(i_ready),
        .i_rsp      (o_item),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ends the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // valid stays up between back-to-back items; only idle cycles lower it
    task automatic send_req(input fqp_pkg::t_in_item req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= req;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    task automatic drain_replies();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // mostly pool handles so purges hit and duplicates occur
    function automatic fqp_pkg::t_in_item random_request(input int enq_pct);
        fqp_pkg::t_in_item req;
        int                pick;
        pick = $urandom_range(99);
        if (pick < enq_pct)
            req.req_type = fqp_pkg::REQ_ENQ;
        else if (pick < enq_pct + (100 - enq_pct) / 2)
            req.req_type = fqp_pkg::REQ_DEQ;
        else if (pick < 97)
            req.req_type = fqp_pkg::REQ_PURGE;
        else
            req.req_type = REQ_UNUSED;
        pick = $urandom_range(99);
        if (pick < 5)
            req.item_handle = '0;
        else if (pick < 20)
            req.item_handle = fqp_pkg::HANDLE_W'($urandom_range(16'hFFFF));
        else
            req.item_handle = handle_pool[$urandom_range(POOL_N - 1)];
        return req;
    endfunction

    initial begin
        bit filling;
        filling = 1'b0;
        foreach (handle_pool[i])
            handle_pool[i] = fqp_pkg::HANDLE_W'($urandom_range(16'hFFFF, 1));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 55 : 0;
            recv_idle_pct <= (ph == 0) ? 55 : (ph == 1) ? 22 : 0;

            if (ph == 0) begin
                send_req(fqp_pkg::t_in_item'{fqp_pkg::REQ_DEQ, 16'h0000});
                send_req(fqp_pkg::t_in_item'{fqp_pkg::REQ_PURGE, 16'h1234});
                // null wins over empty
                send_req(fqp_pkg::t_in_item'{fqp_pkg::REQ_PURGE, 16'h0000});
                send_req(fqp_pkg::t_in_item'{fqp_pkg::REQ_ENQ, 16'h0000});
                send_req(fqp_pkg::t_in_item'{REQ_UNUSED, 16'hFFFF});
                // fill to the top, with one duplicate handle
                for (int i = 0; i < QUEUE_DEPTH; i++)
                    send_req(fqp_pkg::t_in_item'{fqp_pkg::REQ_ENQ,
                        (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0001 :
                        (i == 10) ? 16'h1004 : fqp_pkg::HANDLE_W'(16'h1000 + i)});
                send_req(fqp_pkg::t_in_item'{fqp_pkg::REQ_ENQ, 16'h7777});
                send_req(fqp_pkg::t_in_item'{fqp_pkg::REQ_PURGE, 16'h4321});
                send_req(fqp_pkg::t_in_item'{fqp_pkg::REQ_PURGE, 16'h1004});
                send_req(fqp_pkg::t_in_item'{fqp_pkg::REQ_PURGE, 16'h100F});
                send_req(fqp_pkg::t_in_item'{fqp_pkg::REQ_DEQ, 16'hFFFF});
                send_req(fqp_pkg::t_in_item'{fqp_pkg::REQ_PURGE, 16'h0000});
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % BURST_LEN == 0)
                    filling = !filling;
                send_req(random_request(filling ? 75 : 25));
            end
            drain_replies();
        end

        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
